>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the compressor checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define LZW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzw check failed");

// Next-cycle implication, sampled on clk and switched off during reset.
`define LZW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzw check failed");

`endif

>>> rtl/core/lzw_pkg.sv
// ----------------------------------------------------------------------------
// LZW compressor package
// Shared constants and the item type passed from the front to the back.
// ----------------------------------------------------------------------------
package lzw_pkg;

    localparam int MAX_WIDTH_DEF  = 12;
    localparam int DICT_SIZE_DEF  = 4096;
    localparam int HASH_SLOTS_DEF = 8192;

    localparam int CLEAR_CODE = 256;
    localparam int FIRST_CODE = 257;
    localparam int MIN_WIDTH  = 9;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       first;
    } item_t;

endpackage

>>> rtl/core/lzw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/lzw_front.sv
// ----------------------------------------------------------------------------
// LZW front end
// Accepts input beats, marks the first byte of each stream and queues them.
// ----------------------------------------------------------------------------
module lzw_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    input  logic           hold,
    output logic           q_valid,
    output lzw_pkg::item_t q_item,
    input  logic           q_pop
);

    import lzw_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    item_t             mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              first_reg, first_next;
    logic              push;
    logic              pop;
    item_t             new_item;

    assign in_stall = (cnt_reg == CNT_W'(Q_DEPTH)) || hold;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rptr_reg];

    always_comb
    begin
        new_item.data  = in_byte;
        new_item.last  = in_last;
        new_item.first = first_reg;
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        if (push)
        begin
            wptr_next  = (wptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            first_next = in_last;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            cnt_reg   <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= new_item;
        end
    end

endmodule

>>> rtl/core/lzw_back.sv
// ----------------------------------------------------------------------------
// LZW back end
// Probes the hashed dictionary, inserts new entries, packs the codes and sweeps the dictionary clear.
// ----------------------------------------------------------------------------
module lzw_back #(
    parameter int MAX_WIDTH  = lzw_pkg::MAX_WIDTH_DEF,
    parameter int DICT_SIZE  = lzw_pkg::DICT_SIZE_DEF,
    parameter int HASH_SLOTS = lzw_pkg::HASH_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  lzw_pkg::item_t q_item,
    output logic           q_pop,
    output logic           sweeping,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_byte,
    output logic [3:0]     out_bits,
    output logic           out_last
);

    import lzw_pkg::*;

    localparam int IDX_W = $clog2(HASH_SLOTS);
    localparam int CW_W  = $clog2(MAX_WIDTH + 1);
    localparam int DC_W  = $clog2(DICT_SIZE);
    localparam int NC_W  = ((DC_W > MAX_WIDTH) ? DC_W : MAX_WIDTH) + 1;
    localparam int KEY_W = MAX_WIDTH + 8;
    localparam int ENT_W = 1 + KEY_W + MAX_WIDTH;
    localparam int OB_W  = MAX_WIDTH + 7;
    localparam int OC_W  = $clog2(OB_W + 1);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_PROBE   = 8'b0000_0010,
        ST_MISS    = 8'b0000_0100,
        ST_CLRCODE = 8'b0000_1000,
        ST_FLUSH   = 8'b0001_0000,
        ST_DRAIN   = 8'b0010_0000,
        ST_PAD     = 8'b0100_0000,
        ST_SWEEP   = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [MAX_WIDTH-1:0] prefix_reg, prefix_next;
    logic [CW_W-1:0]     width_reg, width_next;
    logic [NC_W-1:0]     ncode_reg, ncode_next;
    logic [7:0]          byte_reg, byte_next;
    logic                last_reg, last_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    probe_reg, probe_next;
    logic [IDX_W-1:0]    sweep_reg, sweep_next;
    logic                free_reg, free_next;
    logic                dirty_reg, dirty_next;
    logic                final_reg, final_next;
    logic [OB_W-1:0]     obuf_reg, obuf_next;
    logic [OC_W-1:0]     ocnt_reg, ocnt_next;
    logic                oval_reg, oval_next;
    logic [7:0]          obyte_reg, obyte_next;
    logic [3:0]          obits_reg, obits_next;
    logic                olast_reg, olast_next;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENT_W-1:0]    wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [ENT_W-1:0]    rd_data;

    logic                ent_valid;
    logic [KEY_W-1:0]    ent_key;
    logic [MAX_WIDTH-1:0] ent_code;
    logic [31:0]         hash_prod;
    logic [IDX_W-1:0]    hash_idx;
    logic                out_free;
    logic [MAX_WIDTH-1:0] put_code;
    logic [MAX_WIDTH-1:0] put_rev;
    logic [MAX_WIDTH-1:0] put_aligned;
    logic [OB_W-1:0]     put_bits;
    logic [OC_W-1:0]     put_cnt;
    logic [NC_W-1:0]     ncode_inc;

    lzw_ram #(
        .WIDTH (ENT_W),
        .DEPTH (HASH_SLOTS)
    ) u_dict (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ent_valid = rd_data[ENT_W-1];
    assign ent_key   = rd_data[ENT_W-2 -: KEY_W];
    assign ent_code  = rd_data[MAX_WIDTH-1:0];
    assign hash_prod = 32'(q_item.data) * HASH_MULT;
    assign hash_idx  = IDX_W'(32'(prefix_reg) ^ hash_prod);
    assign out_free  = !oval_reg || !out_stall;
    assign ncode_inc = ncode_reg + 1'b1;
    assign sweeping  = (state_reg == ST_SWEEP);

    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            put_rev[i] = put_code[MAX_WIDTH-1-i];
        end
    end

    assign put_aligned = put_rev >> (CW_W'(MAX_WIDTH) - width_reg);
    assign put_bits    = obuf_reg | (OB_W'(put_aligned) << ocnt_reg);
    assign put_cnt     = ocnt_reg + OC_W'(width_reg);

    always_comb
    begin
        unique case (state_reg)
            ST_CLRCODE: put_code = MAX_WIDTH'(CLEAR_CODE);
            default:    put_code = prefix_reg;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        prefix_next = prefix_reg;
        width_next  = width_reg;
        ncode_next  = ncode_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        probe_next  = probe_reg;
        sweep_next  = sweep_reg;
        free_next   = free_reg;
        dirty_next  = dirty_reg;
        final_next  = final_reg;
        obuf_next   = obuf_reg;
        ocnt_next   = ocnt_reg;
        oval_next   = oval_reg && out_stall;
        obyte_next  = obyte_reg;
        obits_next  = obits_reg;
        olast_next  = olast_reg;
        q_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = {1'b1, key_reg, MAX_WIDTH'(ncode_reg)};
        rd_en       = 1'b0;
        rd_addr     = hash_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    byte_next = q_item.data;
                    last_next = q_item.last;
                    if (q_item.first)
                    begin
                        prefix_next = MAX_WIDTH'(q_item.data);
                        state_next  = q_item.last ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = hash_idx;
                        key_next   = {prefix_reg, q_item.data};
                        idx_next   = hash_idx;
                        probe_next = '0;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (!ent_valid)
                begin
                    free_next  = 1'b1;
                    state_next = ST_MISS;
                end
                else if (ent_key == key_reg)
                begin
                    prefix_next = ent_code;
                    state_next  = last_reg ? ST_FLUSH : ST_IDLE;
                end
                else if (probe_reg == IDX_W'(HASH_SLOTS - 1))
                begin
                    free_next  = 1'b0;
                    state_next = ST_MISS;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg + 1'b1;
                end
            end
            ST_MISS:
            begin
                obuf_next   = put_bits;
                ocnt_next   = put_cnt;
                prefix_next = MAX_WIDTH'(byte_reg);
                state_next  = ST_DRAIN;
                if (ncode_reg < NC_W'(DICT_SIZE))
                begin
                    if (free_reg)
                    begin
                        wr_en      = 1'b1;
                        dirty_next = 1'b1;
                    end
                    ncode_next = ncode_inc;
                    if ((width_reg < CW_W'(MAX_WIDTH)) && (ncode_inc > (NC_W'(1) << width_reg)))
                    begin
                        width_next = width_reg + 1'b1;
                    end
                    ret_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
                else
                begin
                    ret_next = ST_CLRCODE;
                end
            end
            ST_CLRCODE:
            begin
                obuf_next  = put_bits;
                ocnt_next  = put_cnt;
                width_next = CW_W'(MIN_WIDTH);
                ncode_next = NC_W'(FIRST_CODE);
                state_next = ST_DRAIN;
                if (last_reg)
                begin
                    ret_next = ST_FLUSH;
                end
                else
                begin
                    ret_next = dirty_reg ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                obuf_next  = put_bits;
                ocnt_next  = put_cnt;
                final_next = 1'b1;
                ret_next   = ST_PAD;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (ocnt_reg >= OC_W'(8))
                begin
                    if (out_free)
                    begin
                        oval_next  = 1'b1;
                        obyte_next = obuf_reg[7:0];
                        obits_next = 4'd8;
                        olast_next = final_reg && (ocnt_reg == OC_W'(8));
                        obuf_next  = obuf_reg >> 8;
                        ocnt_next  = ocnt_reg - OC_W'(8);
                    end
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            ST_PAD:
            begin
                if ((ocnt_reg == '0) || out_free)
                begin
                    if (ocnt_reg != '0)
                    begin
                        oval_next  = 1'b1;
                        obyte_next = obuf_reg[7:0];
                        obits_next = 4'(ocnt_reg);
                        olast_next = 1'b1;
                    end
                    prefix_next = '0;
                    width_next  = CW_W'(MIN_WIDTH);
                    ncode_next  = NC_W'(FIRST_CODE);
                    obuf_next   = '0;
                    ocnt_next   = '0;
                    final_next  = 1'b0;
                    state_next  = dirty_reg ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == IDX_W'(HASH_SLOTS - 1))
                begin
                    dirty_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            ret_reg    <= ST_IDLE;
            prefix_reg <= '0;
            width_reg  <= CW_W'(MIN_WIDTH);
            ncode_reg  <= NC_W'(FIRST_CODE);
            sweep_reg  <= '0;
            dirty_reg  <= 1'b1;
            final_reg  <= 1'b0;
            obuf_reg   <= '0;
            ocnt_reg   <= '0;
            oval_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            prefix_reg <= prefix_next;
            width_reg  <= width_next;
            ncode_reg  <= ncode_next;
            sweep_reg  <= sweep_next;
            dirty_reg  <= dirty_next;
            final_reg  <= final_next;
            obuf_reg   <= obuf_next;
            ocnt_reg   <= ocnt_next;
            oval_reg   <= oval_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        key_reg   <= key_next;
        idx_reg   <= idx_next;
        probe_reg <= probe_next;
        free_reg  <= free_next;
        obyte_reg <= obyte_next;
        obits_reg <= obits_next;
        olast_reg <= olast_next;
    end

    assign out_valid = oval_reg;
    assign out_byte  = obyte_reg;
    assign out_bits  = obits_reg;
    assign out_last  = olast_reg;

endmodule

>>> rtl/core/lzw_compressor_unit.sv
// ----------------------------------------------------------------------------
// LZW compressor unit
// Byte stream in, variable-width LZW codes packed into bytes out.
// ----------------------------------------------------------------------------
// A byte whose (prefix, byte) pair is found at the first hashed slot passes
// through ST_IDLE for the dictionary read and ST_PROBE to check it; each
// further linear probe is one more ST_PROBE step on the single read port of
// the dictionary RAM. A miss places each code into the bit packer in ST_MISS,
// then ST_DRAIN sends one output beat per full byte and leaves the packer
// once fewer than eight bits remain. After reset, and after a stream end or
// dictionary clear that follows any insertion, the dictionary is cleared in a
// pass over all HASH_SLOTS slots (8192 by default) during which no input beat
// is taken. A two-entry queue lets input beats arrive while the back end works.
module lzw_compressor_unit #(
    parameter int MAX_WIDTH  = lzw_pkg::MAX_WIDTH_DEF,
    parameter int DICT_SIZE  = lzw_pkg::DICT_SIZE_DEF,
    parameter int HASH_SLOTS = lzw_pkg::HASH_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [3:0] out_bits,
    output logic       out_last
);

    import lzw_pkg::*;

    logic  q_valid;
    item_t q_item;
    logic  q_pop;
    logic  sweeping;

    lzw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .hold     (sweeping),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    lzw_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .DICT_SIZE  (DICT_SIZE),
        .HASH_SLOTS (HASH_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .sweeping  (sweeping),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_bits  (out_bits),
        .out_last  (out_last)
    );

endmodule

>>> rtl/core/lzw_checker.sv
// ----------------------------------------------------------------------------
// LZW compressor checker
// Port-level assertions on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic [3:0] out_bits,
    input logic       out_last
);

    `LZW_ASSERT_NXT(a_valid_holds, out_valid && out_stall, out_valid)
    `LZW_ASSERT_NXT(a_byte_holds, out_valid && out_stall, $stable(out_byte))
    `LZW_ASSERT_IMP(a_bits_range, out_valid, (out_bits >= 4'd1) && (out_bits <= 4'd8))
    `LZW_ASSERT_IMP(a_partial_is_last, out_valid && (out_bits != 4'd8), out_last)
    `LZW_ASSERT_IMP(a_pad_zero, out_valid, (out_byte >> out_bits) == 8'd0)

endmodule

bind lzw_compressor_unit lzw_checker u_checker (.*);
